>>> design/open_addressing_hash_table_unit_defines.svh
// Assertion macros shared by the hash table unit modules.
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OAHT_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OAHT_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/oaht_pkg.sv
// Constants, codes, types and helper functions of the hash table unit.
`default_nettype none

package oaht_pkg;

  // Table geometry
  localparam int TABLE_DEPTH   = 1024;
  localparam int PROBE_LIMIT   = 5;
  localparam int KEY_BYTES_MAX = 8;

  localparam int SLOT_W  = $clog2(TABLE_DEPTH);
  localparam int M_W     = SLOT_W + 1;
  localparam int SIZE_W  = 11;
  localparam int KEY_W   = 64;
  localparam int LEN_W   = 4;
  localparam int ACT_W   = 2;
  localparam int STATUS_W = 3;
  localparam int SUM_W   = $clog2(KEY_BYTES_MAX * 255 + 1);
  localparam int STEP_W  = $clog2(SUM_W + 1);
  localparam int PCNT_W  = $clog2(PROBE_LIMIT + 1);

  // Request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Stream payload widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  // Register file
  localparam int CFG_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_TABLE_SIZE = '0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  // Action codes (codes 2 and 3 act as a search)
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;

  // Classified request: masked key, clamped length and home slot
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [SLOT_W-1:0] home;
  } oaht_req_t;

  // Result, status in the low bits
  typedef struct packed {
    logic [SIZE_W-1:0]   entry_count;
    logic [SLOT_W-1:0]   slot_index;
    logic [STATUS_W-1:0] status;
  } oaht_rsp_t;

  // Effective modulus: zero reads as one, oversize saturates to the depth
  function automatic logic [M_W-1:0] eff_size(input logic [SIZE_W-1:0] ts);
    logic [M_W-1:0] m;
    if (ts == '0) begin
      m = M_W'(1);
    end else if (ts > SIZE_W'(TABLE_DEPTH)) begin
      m = M_W'(TABLE_DEPTH);
    end else begin
      m = M_W'(ts);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> design/oaht_front.sv
// Front end: takes requests, masks the key, hashes it and reduces the hash bit-serially.
`default_nettype none
`include "open_addressing_hash_table_unit_defines.svh"

module oaht_front import oaht_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] table_size,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic [KEY_W-1:0]  key_bytes,
  input  logic [LEN_W-1:0]  key_length,
  output logic              push_valid,
  input  logic              push_ready,
  output oaht_req_t         push_item
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  sum_q;
  logic [SLOT_W-1:0] rem;
  logic [ACT_W-1:0]  act_q;
  logic [KEY_W-1:0]  key_q;
  logic [LEN_W-1:0]  len_q;

  logic [M_W-1:0]    m_eff;
  logic [LEN_W-1:0]  len_sat;
  logic [KEY_W-1:0]  key_mask;
  logic [SUM_W-1:0]  byte_sum;
  logic [M_W-1:0]    rem_shift;
  logic [SLOT_W-1:0] rem_next;

  always_comb begin
    m_eff   = eff_size(table_size);
    len_sat = (key_length > LEN_W'(KEY_BYTES_MAX)) ? LEN_W'(KEY_BYTES_MAX) : key_length;
    key_mask = '0;
    byte_sum = '0;
    for (int i = 0; i < KEY_BYTES_MAX; i++) begin
      if (LEN_W'(i) < len_sat) begin
        key_mask[8*i +: 8] = key_bytes[8*i +: 8];
        byte_sum = byte_sum + SUM_W'(key_bytes[8*i +: 8]);
      end
    end
    // one restoring step of sum % m, MSB first
    rem_shift = {rem, sum_q[SUM_W-1]};
    rem_next  = (rem_shift >= m_eff) ? SLOT_W'(rem_shift - m_eff) : SLOT_W'(rem_shift);
  end

  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_item  = '{action: act_q, key: key_q, len: len_q, home: rem};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= F_DIV;
            step  <= STEP_W'(SUM_W);
          end
        end
        F_DIV: begin
          step <= step - 1'b1;
          if (step == STEP_W'(1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      act_q <= action;
      key_q <= key_mask;
      len_q <= len_sat;
      sum_q <= byte_sum;
      rem   <= '0;
    end else if (state == F_DIV) begin
      rem   <= rem_next;
      sum_q <= {sum_q[SUM_W-2:0], 1'b0};
    end
  end

  `OAHT_CHECK(a_home_in_table, push_valid, M_W'(push_item.home) < m_eff, "home slot outside table")

endmodule

`default_nettype wire

>>> design/oaht_queue.sv
// Short request queue that decouples the hashing front from the probing back.
`default_nettype none
`include "open_addressing_hash_table_unit_defines.svh"

module oaht_queue import oaht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  oaht_req_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output oaht_req_t pop_item
);

  oaht_req_t          fifo_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push_fire;
  logic               pop_fire;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = fifo_mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      fifo_mem[wr_ptr] <= push_item;
    end
  end

  `OAHT_CHECK_NEXT(a_q_fill, push_fire && !pop_fire, count == $past(count) + 1'b1, "queue fill count slipped")

endmodule

`default_nettype wire

>>> design/oaht_back.sv
// Back end: slot memories, probe run, table update and result register.
`default_nettype none
`include "open_addressing_hash_table_unit_defines.svh"

module oaht_back import oaht_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] table_size,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  oaht_req_t         pop_item,
  output logic              out_valid,
  input  logic              out_ready,
  output oaht_rsp_t         out_rsp,
  output logic              clearing
);

  localparam logic [2:0] B_CLEAR  = 3'd0;
  localparam logic [2:0] B_IDLE   = 3'd1;
  localparam logic [2:0] B_PROBE  = 3'd2;
  localparam logic [2:0] B_LAST   = 3'd3;
  localparam logic [2:0] B_FINISH = 3'd4;

  localparam int ENTRY_W = LEN_W + KEY_W;

  // slot store: {length, key} per slot, and the occupied bits
  logic [ENTRY_W-1:0] key_mem [TABLE_DEPTH];
  logic               occ_mem [TABLE_DEPTH];

  logic [2:0]         state;
  logic [SLOT_W-1:0]  clr_addr;
  oaht_req_t          req;
  logic [SLOT_W-1:0]  cur_slot;
  logic [PCNT_W-1:0]  probe_cnt;
  logic               rd_vld;
  logic [SLOT_W-1:0]  rd_slot;
  logic               rd_occ;
  logic [ENTRY_W-1:0] rd_entry;
  logic               found;
  logic [SLOT_W-1:0]  found_slot;
  logic               free_seen;
  logic [SLOT_W-1:0]  free_slot;
  logic [SIZE_W-1:0]  entry_total;

  logic [M_W-1:0]     m_eff;
  logic [SLOT_W-1:0]  slot_step;
  logic               hit;
  logic               fin_fire;
  oaht_rsp_t          rsp_next;
  logic               key_we;
  logic               occ_we;
  logic [SLOT_W-1:0]  occ_waddr;
  logic               occ_wdata;
  logic [SIZE_W-1:0]  total_next;

  assign m_eff     = eff_size(table_size);
  assign slot_step = (M_W'(cur_slot) + M_W'(1) == m_eff) ? '0 : cur_slot + 1'b1;
  assign hit       = rd_occ && (rd_entry == {req.len, req.key});
  assign fin_fire  = (state == B_FINISH) && (!out_valid || out_ready);
  assign pop_ready = (state == B_IDLE);
  assign clearing  = (state == B_CLEAR);

  always_comb begin
    rsp_next.status     = ST_NOT_FOUND;
    rsp_next.slot_index = '0;
    key_we     = 1'b0;
    occ_we     = 1'b0;
    occ_waddr  = clr_addr;
    occ_wdata  = 1'b0;
    total_next = entry_total;
    if (state == B_CLEAR) begin
      occ_we = 1'b1;
    end else if (fin_fire) begin
      unique case (req.action)
        ACT_INSERT: begin
          if (found) begin
            rsp_next.status     = ST_PRESENT;
            rsp_next.slot_index = found_slot;
          end else if (free_seen) begin
            rsp_next.status     = ST_INSERTED;
            rsp_next.slot_index = free_slot;
            key_we     = 1'b1;
            occ_we     = 1'b1;
            occ_waddr  = free_slot;
            occ_wdata  = 1'b1;
            total_next = entry_total + 1'b1;
          end else begin
            rsp_next.status = ST_FULL;
          end
        end
        ACT_REMOVE: begin
          if (found) begin
            rsp_next.status     = ST_REMOVED;
            rsp_next.slot_index = found_slot;
            occ_we    = 1'b1;
            occ_waddr = found_slot;
            if (entry_total != '0) begin
              total_next = entry_total - 1'b1;
            end
          end
        end
        default: begin
          if (found) begin
            rsp_next.status     = ST_FOUND;
            rsp_next.slot_index = found_slot;
          end
        end
      endcase
    end
    rsp_next.entry_count = total_next;
  end

  // slot memories, registered read at the current probe slot
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[free_slot] <= {req.len, req.key};
    end
    rd_entry <= key_mem[cur_slot];
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    rd_occ <= occ_mem[cur_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_CLEAR;
      clr_addr    <= '0;
      probe_cnt   <= '0;
      rd_vld      <= 1'b0;
      found       <= 1'b0;
      free_seen   <= 1'b0;
      out_valid   <= 1'b0;
      entry_total <= '0;
    end else begin
      rd_vld      <= (state == B_PROBE);
      entry_total <= total_next;
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // first match and first free slot of the run
      if (rd_vld) begin
        if (hit && !found) begin
          found <= 1'b1;
        end
        if (!rd_occ && !free_seen) begin
          free_seen <= 1'b1;
        end
      end
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_W'(TABLE_DEPTH - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop_valid) begin
            state     <= B_PROBE;
            probe_cnt <= '0;
            found     <= 1'b0;
            free_seen <= 1'b0;
          end
        end
        B_PROBE: begin
          probe_cnt <= probe_cnt + 1'b1;
          if (probe_cnt == PCNT_W'(PROBE_LIMIT)) begin
            state <= B_LAST;
          end
        end
        B_LAST: state <= B_FINISH;
        B_FINISH: begin
          if (fin_fire) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop_valid) begin
      req      <= pop_item;
      cur_slot <= pop_item.home;
    end else if (state == B_PROBE) begin
      cur_slot <= slot_step;
    end
    rd_slot <= cur_slot;
    if (rd_vld && hit && !found) begin
      found_slot <= rd_slot;
    end
    if (rd_vld && !rd_occ && !free_seen) begin
      free_slot <= rd_slot;
    end
    if (fin_fire) begin
      out_rsp <= rsp_next;
    end
  end

  `OAHT_CHECK(a_probe_in_table, rd_vld, M_W'(rd_slot) < m_eff, "probe slot outside table")
  `OAHT_CHECK_NEXT(a_insert_count, fin_fire && rsp_next.status == ST_INSERTED, entry_total == $past(entry_total) + 1'b1, "insert did not raise entry count")

endmodule

`default_nettype wire

>>> design/open_addressing_hash_table_unit.sv
// Top level of the open-addressing hash table: stream ports, APB register, front, queue, back.
//
// Usage:
//   s_axis carries one request per transfer: insert, remove or search of a key of
//   up to 8 bytes. m_axis returns exactly one result per request, in order.
//   table_size (APB, byte address 0) sets the slot count in use; write it only
//   while no request is in flight.
// Processing:
//   The front takes one request at a time: it accepts it, reduces the byte sum
//   modulo the table size bit-serially, then pushes it into the queue. Per request,
//   the back pops it, makes six reads of the slot memory, then does a compare
//   step and an update/result step.
// Reset:
//   rst is synchronous. After reset the back sweeps the occupied map, one slot
//   per cycle, over all 1024 slots; s_axis_tready stays low until it finishes.
//   APB writes are taken during the sweep.
// Back pressure:
//   The result waits in an output register while m_axis_tready is low; the
//   front and the two-entry queue keep taking requests until the queue fills.
`default_nettype none

module open_addressing_hash_table_unit import oaht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] action, [65:2] key_bytes, [69:66] key_length, [71:70] zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] status, [12:3] slot_index, [23:13] entry_count
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [SIZE_W-1:0] table_size;
  logic              cfg_sel;
  logic              cfg_wr;

  logic              front_valid;
  logic              front_ready;
  logic              push_valid;
  logic              push_ready;
  oaht_req_t         push_item;
  logic              pop_valid;
  logic              pop_ready;
  oaht_req_t         pop_item;
  oaht_rsp_t         out_rsp;
  logic              clearing;

  // register decode, word index in paddr[2]
  assign cfg_sel = (paddr[CFG_ADDR_W-1:2] == REG_TABLE_SIZE);
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? {{(APB_DATA_W - SIZE_W){1'b0}}, table_size} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (cfg_wr) begin
      table_size <= pwdata[SIZE_W-1:0];
    end
  end

  // no requests while the occupied map is being swept
  assign front_valid   = s_axis_tvalid && !clearing;
  assign s_axis_tready = front_ready && !clearing;

  oaht_front u_front (
    .clk        (clk),
    .rst        (rst),
    .table_size (table_size),
    .in_valid   (front_valid),
    .in_ready   (front_ready),
    .action     (s_axis_tdata[ACT_W-1:0]),
    .key_bytes  (s_axis_tdata[ACT_W +: KEY_W]),
    .key_length (s_axis_tdata[ACT_W + KEY_W +: LEN_W]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  oaht_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  oaht_back u_back (
    .clk        (clk),
    .rst        (rst),
    .table_size (table_size),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_rsp    (out_rsp),
    .clearing   (clearing)
  );

  assign m_axis_tdata = out_rsp;

endmodule

`default_nettype wire
